// ===== rtl/prd_pkg.sv =====
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types and codes of the point-of-interest enter/exit detector.
// ----------------------------------------------------------------------------
package prd_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_EXIT  = 2'd2
  } ev_kind_e;

  localparam logic CFG_EXIT_MULT   = 1'b0;
  localparam logic CFG_ENTRY_COUNT = 1'b1;

  localparam logic [9:0] EXIT_MULT_RESET = 10'd294;

  typedef struct packed {
    ev_kind_e   kind;
    logic [3:0] idx;
    logic       pause;
  } ev_t;

endpackage

// ===== rtl/poi_radius_enter_exit_detector.sv =====
// ----------------------------------------------------------------------------
// poi_radius_enter_exit_detector
// Enter/exit detection of the robot against a table of circular points.
//
//   channel   handshake                 payload
//   command   start / busy              cmd, robot pos, entry fields, nav
//   result    out_strobe_o (no stall)   event_kind, poi_index, pause, last
//   config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A tick token walks the row of cells; events ride a separate bus towards the
// collector. The last result of a tick is marked by last_o and busy falls in
// the cycle after it, so the next transfer can come then. Write and clear
// leave busy low. Reset clears inside bits and the entry count and sets the
// exit multiplier to EXIT_MULT_RESET; the table contents stay unknown until
// written. Results cannot be stalled.
// ----------------------------------------------------------------------------
module poi_radius_enter_exit_detector import prd_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic signed [23:0] robot_x_i,
  input  logic signed [23:0] robot_y_i,
  input  logic [3:0]         entry_index_i,
  input  logic signed [23:0] entry_x_i,
  input  logic signed [23:0] entry_y_i,
  input  logic [15:0]        entry_radius_i,
  input  logic               entry_pause_i,
  input  logic               nav_active_i,
  input  logic               nav_paused_i,
  output logic               out_strobe_o,
  output logic [1:0]         event_kind_o,
  output logic [3:0]         poi_index_o,
  output logic               pause_request_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [9:0]         cfg_data_i
);

  logic       busy_q, busy_d;
  logic       pause_ok_q;
  logic [9:0] mult_q;
  logic [4:0] count_q;
  logic       accept, tick, wr, clr;

  logic               tok [TABLE_DEPTH+1];
  logic signed [23:0] rx  [TABLE_DEPTH+1];
  logic signed [23:0] ry  [TABLE_DEPTH+1];
  ev_t                ev  [TABLE_DEPTH+1];

  assign accept = start && !busy_q;
  assign tick   = accept && (cmd_i == CMD_TICK);
  assign wr     = accept && (cmd_i == CMD_WRITE);
  assign clr    = accept && (cmd_i == CMD_CLEAR);

  assign tok[0] = tick;
  assign rx[0]  = robot_x_i;
  assign ry[0]  = robot_y_i;
  assign ev[0]  = '0;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    prd_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (4'(k)),
      .enable_i (32'(k) < 32'(count_q)),
      .mult_i   (mult_q),
      .clear_i  (clr),
      .wr_en_i  (wr && (32'(entry_index_i) == 32'(k))),
      .wr_x_i   (entry_x_i),
      .wr_y_i   (entry_y_i),
      .wr_r_i   (entry_radius_i),
      .wr_p_i   (entry_pause_i),
      .tok_i    (tok[k]),
      .rx_i     (rx[k]),
      .ry_i     (ry[k]),
      .ev_i     (ev[k]),
      .tok_o    (tok[k+1]),
      .rx_o     (rx[k+1]),
      .ry_o     (ry[k+1]),
      .ev_o     (ev[k+1])
    );
  end

  prd_collect u_collect (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ev_i            (ev[TABLE_DEPTH]),
    .done_i          (tok[TABLE_DEPTH]),
    .pause_ok_i      (pause_ok_q),
    .out_strobe_o    (out_strobe_o),
    .event_kind_o    (event_kind_o),
    .poi_index_o     (poi_index_o),
    .pause_request_o (pause_request_o),
    .last_o          (last_o)
  );

  always_comb begin
    busy_d = busy_q;
    if (tick) begin
      busy_d = 1'b1;
    end else if (out_strobe_o && last_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      pause_ok_q <= nav_active_i && !nav_paused_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      mult_q  <= EXIT_MULT_RESET;
      count_q <= '0;
    end else begin
      busy_q <= busy_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_EXIT_MULT:   mult_q  <= cfg_data_i;
          CFG_ENTRY_COUNT: count_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
    end
  end

  assign busy        = busy_q;
  assign cfg_ready_o = 1'b1;

endmodule

// ===== rtl/prd_cell.sv =====
// ----------------------------------------------------------------------------
// prd_cell
// One table entry with its inside bit and a three-stage distance check.
// ----------------------------------------------------------------------------
module prd_cell import prd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [3:0]         idx_i,
  input  logic               enable_i,
  input  logic [9:0]         mult_i,
  input  logic               clear_i,
  input  logic               wr_en_i,
  input  logic signed [23:0] wr_x_i,
  input  logic signed [23:0] wr_y_i,
  input  logic [15:0]        wr_r_i,
  input  logic               wr_p_i,
  input  logic               tok_i,
  input  logic signed [23:0] rx_i,
  input  logic signed [23:0] ry_i,
  input  ev_t                ev_i,
  output logic               tok_o,
  output logic signed [23:0] rx_o,
  output logic signed [23:0] ry_o,
  output ev_t                ev_o
);

  logic signed [23:0] x_q, y_q;
  logic [15:0]        r_q;
  logic               p_q;
  logic               inside_q, inside_d;

  logic signed [23:0] rx_q, ry_q;
  logic               v1_q, v2_q, tok_q;
  logic [24:0]        ax1_q, ay1_q;
  logic [25:0]        rm1_q;
  logic [31:0]        rr1_q, rr2_q;
  logic [49:0]        sx2_q, sy2_q;
  logic [35:0]        tt2_q;
  ev_t                ev_q, ev_d;

  logic signed [24:0] dx, dy;
  logic [24:0]        ax, ay;
  logic [17:0]        thr;
  logic [50:0]        d2;
  logic               enter, leave;

  always_comb begin
    dx = $signed({x_q[23], x_q}) - $signed({rx_i[23], rx_i});
    dy = $signed({y_q[23], y_q}) - $signed({ry_i[23], ry_i});
    ax = dx[24] ? 25'(-dx) : 25'(dx);
    ay = dy[24] ? 25'(-dy) : 25'(dy);
    thr = rm1_q[25:8];
    d2 = {1'b0, sx2_q} + {1'b0, sy2_q};
    enter = v2_q && enable_i && !inside_q && (d2 <= {19'd0, rr2_q});
    leave = v2_q && enable_i && inside_q && (d2 > {15'd0, tt2_q});
    inside_d = inside_q;
    if (enter) begin
      inside_d = 1'b1;
    end else if (leave) begin
      inside_d = 1'b0;
    end
    if (clear_i) begin
      inside_d = 1'b0;
    end
    ev_d = ev_i;
    if (enter) begin
      ev_d.kind  = EV_ENTER;
      ev_d.idx   = idx_i;
      ev_d.pause = p_q;
    end else if (leave) begin
      ev_d.kind  = EV_EXIT;
      ev_d.idx   = idx_i;
      ev_d.pause = 1'b0;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      x_q <= wr_x_i;
      y_q <= wr_y_i;
      r_q <= wr_r_i;
      p_q <= wr_p_i;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (tok_i) begin
      rx_q  <= rx_i;
      ry_q  <= ry_i;
      ax1_q <= ax;
      ay1_q <= ay;
      rm1_q <= {10'd0, r_q} * {16'd0, mult_i};
      rr1_q <= {16'd0, r_q} * {16'd0, r_q};
    end
    if (v1_q) begin
      sx2_q <= {25'd0, ax1_q} * {25'd0, ax1_q};
      sy2_q <= {25'd0, ay1_q} * {25'd0, ay1_q};
      tt2_q <= {18'd0, thr} * {18'd0, thr};
      rr2_q <= rr1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      tok_q    <= 1'b0;
      ev_q     <= '0;
    end else begin
      inside_q <= inside_d;
      v1_q     <= tok_i;
      v2_q     <= v1_q;
      tok_q    <= v2_q;
      ev_q     <= ev_d;
    end
  end

  assign tok_o = tok_q;
  assign rx_o  = rx_q;
  assign ry_o  = ry_q;
  assign ev_o  = ev_q;

endmodule

// ===== rtl/prd_collect.sv =====
// ----------------------------------------------------------------------------
// prd_collect
// Holds back one event so the final result of a tick can be marked last.
// ----------------------------------------------------------------------------
module prd_collect import prd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ev_t        ev_i,
  input  logic       done_i,
  input  logic       pause_ok_i,
  output logic       out_strobe_o,
  output logic [1:0] event_kind_o,
  output logic [3:0] poi_index_o,
  output logic       pause_request_o,
  output logic       last_o
);

  ev_t        hold_q, hold_d;
  logic       hold_v_q, hold_v_d;
  logic       hit_q, hit_d;
  logic       done_q;
  logic       strobe_q, strobe_d;
  ev_kind_e   kind_q, kind_d;
  logic [3:0] idx_q, idx_d;
  logic       pause_q, pause_d;
  logic       last_q, last_d;

  always_comb begin
    hold_d   = hold_q;
    hold_v_d = hold_v_q;
    hit_d    = hit_q;
    strobe_d = 1'b0;
    kind_d   = EV_NONE;
    idx_d    = '0;
    pause_d  = 1'b0;
    last_d   = 1'b0;
    if (ev_i.kind != EV_NONE) begin
      if (hold_v_q) begin
        strobe_d = 1'b1;
        kind_d   = hold_q.kind;
        idx_d    = hold_q.idx;
      end
      hold_d   = ev_i;
      hold_v_d = 1'b1;
      hit_d    = hit_q | ev_i.pause;
    end
    if (done_q) begin
      strobe_d = 1'b1;
      last_d   = 1'b1;
      pause_d  = hit_q & pause_ok_i;
      if (hold_v_q) begin
        kind_d = hold_q.kind;
        idx_d  = hold_q.idx;
      end
      hold_v_d = 1'b0;
      hit_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q  <= hold_d;
    kind_q  <= kind_d;
    idx_q   <= idx_d;
    pause_q <= pause_d;
    last_q  <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      hit_q    <= 1'b0;
      done_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      hold_v_q <= hold_v_d;
      hit_q    <= hit_d;
      done_q   <= done_i;
      strobe_q <= strobe_d;
    end
  end

  assign out_strobe_o    = strobe_q;
  assign event_kind_o    = kind_q;
  assign poi_index_o     = idx_q;
  assign pause_request_o = pause_q;
  assign last_o          = last_q;

endmodule
